// ===== hdl/bbc_pkg.sv =====
// Package for the block buffer cache tag manager.
// Holds the field widths, the entry record, the operation, status and state codes.
// No dependencies.
package bbc_pkg;

  localparam int ENTRIES_DEF = 32;

  localparam int ACT_W   = 2;
  localparam int DEV_W   = 8;
  localparam int BLK_W   = 32;
  localparam int BIDX_W  = 5;
  localparam int STAMP_W = 32;
  localparam int REF_W   = 8;
  localparam int ST_W    = 2;

  localparam logic [REF_W-1:0] REF_MAX = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_READ    = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_PIN     = 2'd2,
    ACT_UNPIN   = 2'd3
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_UNDER  = 2'd2,
    ST_OVER   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DECIDE,
    FSM_OP
  } state_e;

  // One tag table entry as stored in the memory.
  typedef struct packed {
    logic               present;
    logic [DEV_W-1:0]   device;
    logic [BLK_W-1:0]   block;
    logic [REF_W-1:0]   refs;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Summary of a table scan, handed from the scan unit to the controller.
  typedef struct packed {
    logic               hit;
    logic               found;
    logic [REF_W-1:0]   hit_refs;
    logic [STAMP_W-1:0] hit_stamp;
    logic [STAMP_W-1:0] limit;
  } scan_t;

endpackage

// ===== hdl/block_buffer_cache_lru_top.sv =====
// Top level of the buffer cache tag manager with timestamp LRU replacement.
// Holds the controller and the result register; uses bbc_mem, bbc_scan and bbc_pkg.
//
//   Channel | Valid       | Stall       | Payload
//   --------+-------------+-------------+------------------------------------------------
//   in      | in_valid_i  | in_stall_o  | action_i device_i block_number_i buffer_index_i now_i
//   out     | out_valid_o | out_stall_i | entry_index_o hit_o needs_read_o status_o
//           |             |             | reference_count_o
//
// A read transaction scans the whole table: the table sits in one memory with a single
// read port, and the scan reads one entry per cycle. Release, pin and unpin take one
// memory read and one write back.
// The block works on one transaction at a time; a new one is taken while the previous
// result still waits in the output register. A stalled output holds the write back.
// Reset clears per-entry valid bits at once, so there is no clearing pass.
module block_buffer_cache_lru_top import bbc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ACT_W-1:0]   action_i,
  input  logic [DEV_W-1:0]   device_i,
  input  logic [BLK_W-1:0]   block_number_i,
  input  logic [BIDX_W-1:0]  buffer_index_i,
  input  logic [STAMP_W-1:0] now_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BIDX_W-1:0]  entry_index_o,
  output logic               hit_o,
  output logic               needs_read_o,
  output logic [ST_W-1:0]    status_o,
  output logic [REF_W-1:0]   reference_count_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  state_e             state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;

  // Latched request of the transaction in progress.
  logic [ACT_W-1:0]   act_q;
  logic [DEV_W-1:0]   dev_q;
  logic [BLK_W-1:0]   blk_q;
  logic [BIDX_W-1:0]  bidx_q;
  logic [STAMP_W-1:0] now_q;
  logic               in_range_q;

  logic               in_acc, out_free, load;
  logic               in_range;

  // Memory port signals.
  logic               mem_we, mem_re;
  logic [IW-1:0]      mem_wa, mem_ra;
  entry_t             mem_wd, mem_rd;

  // Scan results.
  scan_t              scan;
  logic [IW-1:0]      hit_idx, pick_idx;

  // Result being formed and the output register.
  logic [BIDX_W-1:0]  res_idx;
  logic               res_hit, res_rd;
  status_e            res_st;
  logic [REF_W-1:0]   res_cnt, new_refs;
  logic               out_valid_q;
  logic [BIDX_W-1:0]  out_idx_q;
  logic               out_hit_q, out_rd_q;
  status_e            out_st_q;
  logic [REF_W-1:0]   out_cnt_q;

  assign in_stall_o = (state_q != FSM_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_range   = (32'(buffer_index_i) < 32'(ENTRIES));

  bbc_mem #(
    .ENTRIES(ENTRIES),
    .IW     (IW)
  ) u_mem (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .we_i  (mem_we),
    .wa_i  (mem_wa),
    .wd_i  (mem_wd),
    .re_i  (mem_re),
    .ra_i  (mem_ra),
    .rd_o  (mem_rd)
  );

  // The scan evaluates the entry read in the previous cycle, hence the index one behind.
  bbc_scan #(
    .ENTRIES(ENTRIES),
    .IW     (IW)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (in_acc),
    .now_i     (now_i),
    .eval_i    (state_q == FSM_SCAN),
    .eval_idx_i(IW'(cnt_q - CW'(1))),
    .entry_i   (mem_rd),
    .dev_i     (dev_q),
    .blk_i     (blk_q),
    .scan_o    (scan),
    .hit_idx_o (hit_idx),
    .pick_idx_o(pick_idx)
  );

  // Request latch.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q      <= action_i;
      dev_q      <= device_i;
      blk_q      <= block_number_i;
      bidx_q     <= buffer_index_i;
      now_q      <= now_i;
      in_range_q <= in_range;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          cnt_d   = CW'(1);
          state_d = (action_i == ACT_READ) ? FSM_SCAN : FSM_OP;
        end
      end
      FSM_SCAN: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(ENTRIES)) begin
          state_d = FSM_DECIDE;
        end
      end
      FSM_DECIDE, FSM_OP: begin
        if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Memory reads: the first entry or the addressed entry at accept, then one entry per
  // scan cycle. An out-of-range buffer index issues no read.
  always_comb begin
    mem_re = 1'b0;
    mem_ra = '0;
    case (state_q)
      FSM_IDLE: begin
        if (action_i == ACT_READ) begin
          mem_re = in_acc;
        end else begin
          mem_re = in_acc && in_range;
          mem_ra = IW'(buffer_index_i);
        end
      end
      FSM_SCAN: begin
        mem_re = (cnt_q < CW'(ENTRIES));
        mem_ra = cnt_q[IW-1:0];
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Outputs: result formation and the write back, both gated by a free output register.
  always_comb begin
    load     = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd   = mem_rd;
    res_idx  = '0;
    res_hit  = 1'b0;
    res_rd   = 1'b0;
    res_st   = ST_OK;
    res_cnt  = '0;
    new_refs = '0;
    case (state_q)
      FSM_DECIDE: begin
        load = out_free;
        if (scan.hit) begin
          res_idx = BIDX_W'(hit_idx);
          res_hit = 1'b1;
          if (scan.hit_refs == REF_MAX) begin
            res_st  = ST_OVER;
            res_cnt = REF_MAX;
          end else begin
            new_refs       = scan.hit_refs + REF_W'(1);
            res_cnt        = new_refs;
            mem_we         = out_free;
            mem_wa         = hit_idx;
            mem_wd.present = 1'b1;
            mem_wd.device  = dev_q;
            mem_wd.block   = blk_q;
            mem_wd.refs    = new_refs;
            mem_wd.stamp   = scan.hit_stamp;
          end
        end else if (scan.found) begin
          // Retag the oldest free entry; its stamp is the final scan limit.
          res_idx        = BIDX_W'(pick_idx);
          res_rd         = 1'b1;
          res_cnt        = REF_W'(1);
          mem_we         = out_free;
          mem_wa         = pick_idx;
          mem_wd.present = 1'b1;
          mem_wd.device  = dev_q;
          mem_wd.block   = blk_q;
          mem_wd.refs    = REF_W'(1);
          mem_wd.stamp   = scan.limit;
        end else begin
          res_st = ST_NOFREE;
        end
      end
      FSM_OP: begin
        load    = out_free;
        res_idx = bidx_q;
        mem_wa  = IW'(bidx_q);
        if (in_range_q) begin
          if (act_q == ACT_PIN) begin
            if (mem_rd.refs == REF_MAX) begin
              res_st  = ST_OVER;
              res_cnt = REF_MAX;
            end else begin
              new_refs    = mem_rd.refs + REF_W'(1);
              res_cnt     = new_refs;
              mem_we      = out_free;
              mem_wd.refs = new_refs;
            end
          end else if (mem_rd.refs == '0) begin
            res_st = ST_UNDER;
          end else begin
            // Release or unpin; a release that frees the entry stamps the current time.
            new_refs    = mem_rd.refs - REF_W'(1);
            res_cnt     = new_refs;
            mem_we      = out_free;
            mem_wd.refs = new_refs;
            if ((act_q == ACT_RELEASE) && (new_refs == '0)) begin
              mem_wd.stamp = now_q;
            end
          end
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_idx_q <= res_idx;
      out_hit_q <= res_hit;
      out_rd_q  <= res_rd;
      out_st_q  <= res_st;
      out_cnt_q <= res_cnt;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign entry_index_o     = out_idx_q;
  assign hit_o             = out_hit_q;
  assign needs_read_o      = out_rd_q;
  assign status_o          = out_st_q;
  assign reference_count_o = out_cnt_q;

`ifndef NO_ASSERTIONS
  // The table is only written when a result is handed to the output register.
  a_write_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> load)
    else $error("table write without a result");

  // The scan counter stays between one and the table size while scanning.
  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_SCAN) |-> ((cnt_q != '0) && (cnt_q <= CW'(ENTRIES))))
    else $error("scan counter out of range");

  // An accepted read transaction goes through the full scan before deciding.
  a_read_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (action_i == ACT_READ)) |=> (state_q == FSM_SCAN))
    else $error("read transaction skipped the scan");

  // A read that found no free entry reports neither a hit nor a retag.
  a_nofree_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_NOFREE)) |-> (!hit_o && !needs_read_o))
    else $error("no-free result carries hit or retag");
`endif

endmodule

// ===== hdl/bbc_mem.sv =====
// Tag table memory: one write port, one registered read port, per-entry valid bits.
// An entry never written since reset reads as all zeros. Depends on bbc_pkg.
module bbc_mem import bbc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IW      = $clog2(ENTRIES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [IW-1:0] wa_i,
  input  entry_t        wd_i,
  input  logic          re_i,
  input  logic [IW-1:0] ra_i,
  output entry_t        rd_o
);

  entry_t               mem [ENTRIES];
  logic [ENTRIES-1:0]   valid_q;
  entry_t               rd_q;
  logic                 rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    if (re_i) begin
      rd_q <= mem[ra_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[wa_i] <= 1'b1;
      end
      if (re_i) begin
        rd_valid_q <= valid_q[ra_i];
      end
    end
  end

  assign rd_o = rd_valid_q ? rd_q : '0;

endmodule

// ===== hdl/bbc_scan.sv =====
// Scan unit: looks at one table entry per cycle, tracks the first tag match and
// the oldest free entry not after the current time. Depends on bbc_pkg.
module bbc_scan import bbc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IW      = $clog2(ENTRIES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic [STAMP_W-1:0] now_i,
  input  logic               eval_i,
  input  logic [IW-1:0]      eval_idx_i,
  input  entry_t             entry_i,
  input  logic [DEV_W-1:0]   dev_i,
  input  logic [BLK_W-1:0]   blk_i,
  output scan_t              scan_o,
  output logic [IW-1:0]      hit_idx_o,
  output logic [IW-1:0]      pick_idx_o
);

  logic               hit_q, found_q;
  logic [IW-1:0]      hit_idx_q, pick_idx_q;
  logic [REF_W-1:0]   hit_refs_q;
  logic [STAMP_W-1:0] hit_stamp_q, limit_q;
  logic               match, cand;

  assign match = entry_i.present && (entry_i.device == dev_i) && (entry_i.block == blk_i);
  // The later of two equal stamps wins, so ties go to the highest index.
  assign cand  = (entry_i.refs == '0) && (entry_i.stamp <= limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      found_q <= 1'b0;
    end else if (clear_i) begin
      hit_q   <= 1'b0;
      found_q <= 1'b0;
    end else if (eval_i) begin
      if (match) begin
        hit_q <= 1'b1;
      end
      if (cand) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      limit_q <= now_i;
    end else if (eval_i) begin
      if (match && !hit_q) begin
        hit_idx_q   <= eval_idx_i;
        hit_refs_q  <= entry_i.refs;
        hit_stamp_q <= entry_i.stamp;
      end
      if (cand) begin
        pick_idx_q <= eval_idx_i;
        limit_q    <= entry_i.stamp;
      end
    end
  end

  assign scan_o.hit       = hit_q;
  assign scan_o.found     = found_q;
  assign scan_o.hit_refs  = hit_refs_q;
  assign scan_o.hit_stamp = hit_stamp_q;
  assign scan_o.limit     = limit_q;
  assign hit_idx_o        = hit_idx_q;
  assign pick_idx_o       = pick_idx_q;

endmodule

// ===== bench/bbc_checker.sv =====
// Scoreboard for the buffer cache tag manager: watches both channels, predicts each result.
// Keeps its own copy of the tag table and compares results in order; depends on bbc_pkg.
module bbc_checker import bbc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [ACT_W-1:0]   action_i,
  input  logic [DEV_W-1:0]   device_i,
  input  logic [BLK_W-1:0]   block_number_i,
  input  logic [BIDX_W-1:0]  buffer_index_i,
  input  logic [STAMP_W-1:0] now_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [BIDX_W-1:0]  entry_index_i,
  input  logic               hit_i,
  input  logic               needs_read_i,
  input  logic [ST_W-1:0]    status_i,
  input  logic [REF_W-1:0]   reference_count_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [BIDX_W-1:0] index;
    logic              hit;
    logic              fetch;
    status_e           status;
    logic [REF_W-1:0]  refs;
  } cache_result_t;

  logic [DEV_W-1:0]   tag_dev   [ENTRIES];
  logic [BLK_W-1:0]   tag_blk   [ENTRIES];
  logic [REF_W-1:0]   use_cnt   [ENTRIES];
  logic [STAMP_W-1:0] rel_stamp [ENTRIES];
  logic               tag_valid [ENTRIES];

  cache_result_t expected_q[$];
  int unsigned   mismatches = 0;
  int unsigned   checked = 0;

  assign errors_o = mismatches;

  // Applies one transaction to the shadow table and returns the result it should give.
  function automatic cache_result_t cache_step(action_e act, logic [DEV_W-1:0] dev,
                                               logic [BLK_W-1:0] blk,
                                               logic [BIDX_W-1:0] bidx,
                                               logic [STAMP_W-1:0] tick);
    cache_result_t      r;
    int                 hit_at;
    int                 pick;
    bit                 found;
    logic [STAMP_W-1:0] limit;
    r = '0;
    r.status = ST_OK;
    if (act == ACT_READ) begin
      hit_at = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_at < 0 && tag_valid[i] && tag_dev[i] == dev && tag_blk[i] == blk) begin
          hit_at = i;
        end
      end
      if (hit_at >= 0) begin
        r.index = BIDX_W'(hit_at);
        r.hit = 1'b1;
        if (use_cnt[hit_at] == REF_MAX) begin
          r.status = ST_OVER;
          r.refs = REF_MAX;
        end else begin
          use_cnt[hit_at] = use_cnt[hit_at] + 1'b1;
          r.refs = use_cnt[hit_at];
        end
        return r;
      end
      // Oldest unreferenced entry not stamped after now; later indexes win ties.
      found = 1'b0;
      pick = 0;
      limit = tick;
      for (int i = 0; i < ENTRIES; i++) begin
        if (use_cnt[i] == '0 && rel_stamp[i] <= limit) begin
          found = 1'b1;
          pick = i;
          limit = rel_stamp[i];
        end
      end
      if (!found) begin
        r.status = ST_NOFREE;
        return r;
      end
      tag_dev[pick] = dev;
      tag_blk[pick] = blk;
      use_cnt[pick] = REF_W'(1);
      tag_valid[pick] = 1'b1;
      r.index = BIDX_W'(pick);
      r.fetch = 1'b1;
      r.refs = REF_W'(1);
    end else if (bidx >= ENTRIES) begin
      r.index = bidx;
    end else if (act == ACT_PIN) begin
      r.index = bidx;
      if (use_cnt[bidx] == REF_MAX) begin
        r.status = ST_OVER;
        r.refs = REF_MAX;
      end else begin
        use_cnt[bidx] = use_cnt[bidx] + 1'b1;
        r.refs = use_cnt[bidx];
      end
    end else begin
      r.index = bidx;
      if (use_cnt[bidx] == '0) begin
        r.status = ST_UNDER;
      end else begin
        use_cnt[bidx] = use_cnt[bidx] - 1'b1;
        if (act == ACT_RELEASE && use_cnt[bidx] == '0) rel_stamp[bidx] = tick;
        r.refs = use_cnt[bidx];
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cache_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tag_dev[i] = '0;
        tag_blk[i] = '0;
        use_cnt[i] = '0;
        rel_stamp[i] = '0;
        tag_valid[i] = 1'b0;
      end
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result idx=%0d hit=%0b read=%0b status=%0d count=%0d",
                     $realtime, entry_index_i, hit_i, needs_read_i, status_i,
                     reference_count_i);
          end
        end else begin
          want = expected_q.pop_front();
          if (entry_index_i !== want.index || hit_i !== want.hit ||
              needs_read_i !== want.fetch || status_i !== want.status ||
              reference_count_i !== want.refs) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result %0d expected idx=%0d hit=%0b read=%0b status=%0d count=%0d",
                       $realtime, checked, want.index, want.hit, want.fetch, want.status,
                       want.refs);
              $display("%0t: result %0d actual   idx=%0d hit=%0b read=%0b status=%0d count=%0d",
                       $realtime, checked, entry_index_i, hit_i, needs_read_i, status_i,
                       reference_count_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(cache_step(action_e'(action_i), device_i, block_number_i,
                                        buffer_index_i, now_i));
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the buffer cache tag manager: clock, reset, stimulus and verdict.
// Instantiates block_buffer_cache_lru_top and the bbc_checker scoreboard; uses bbc_pkg.
module tb;
  import bbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES        = ENTRIES_DEF;
  // Long receiver hold-off, long enough to back the block up onto its input.
  localparam int HOLD_CYCLES    = 300;
  // A transaction-free stretch this long means the block has hung. The slowest legal
  // stretch is a hold-off plus a full read scan plus a sender gap, well under this.
  localparam int WATCHDOG_LIMIT = 3000;
  // Settling time at the end, a little more than one read scan.
  localparam int TAIL_CYCLES    = ENTRIES + 10;
  localparam int BLK_POOL       = 24;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ACT_W-1:0]   action = ACT_READ;
  logic [DEV_W-1:0]   device = '0;
  logic [BLK_W-1:0]   block_number = '0;
  logic [BIDX_W-1:0]  buffer_index = '0;
  logic [STAMP_W-1:0] now = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [BIDX_W-1:0]  entry_index;
  logic               hit;
  logic               needs_read;
  logic [ST_W-1:0]    status;
  logic [REF_W-1:0]   reference_count;

  int unsigned errors;
  int unsigned pending;

  // Idle rates in percent per cycle, changed between phases of the run.
  int tx_idle_pct = 26;
  int rx_idle_pct = 45;

  // The stimulus bumps hold_seq to ask for one long receiver hold-off.
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Running tick count used as "now" for most transactions.
  logic [STAMP_W-1:0] tick;
  logic [DEV_W-1:0]   dev_pool [2];
  logic [BLK_W-1:0]   blk_pool [BLK_POOL];

  // Entry indexes the client currently holds a reference on, learned from results.
  logic [BIDX_W-1:0]  held_q[$];
  logic [BIDX_W-1:0]  last_index = '0;

  int unsigned sent = 0;
  int unsigned results = 0;
  int unsigned hits = 0;
  int unsigned fills = 0;
  int unsigned refusals = 0;
  int unsigned underflows = 0;
  int unsigned overflows = 0;
  int unsigned idle_cycles = 0;

  block_buffer_cache_lru_top #(.ENTRIES(ENTRIES)) i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .action_i          (action),
    .device_i          (device),
    .block_number_i    (block_number),
    .buffer_index_i    (buffer_index),
    .now_i             (now),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .entry_index_o     (entry_index),
    .hit_o             (hit),
    .needs_read_o      (needs_read),
    .status_o          (status),
    .reference_count_o (reference_count)
  );

  bbc_checker #(.ENTRIES(ENTRIES)) i_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .action_i          (action),
    .device_i          (device),
    .block_number_i    (block_number),
    .buffer_index_i    (buffer_index),
    .now_i             (now),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .entry_index_i     (entry_index),
    .hit_i             (hit),
    .needs_read_i      (needs_read),
    .status_i          (status),
    .reference_count_i (reference_count),
    .errors_o          (errors),
    .pending_o         (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side: random stall at the current rate, or a long hold-off on request.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Result monitor for stimulus feedback and the closing summary. Every read that
  // succeeds leaves the client holding a reference on the granted entry.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results++;
      last_index = entry_index;
      if (hit) hits++;
      if (needs_read) fills++;
      if (status == ST_NOFREE) refusals++;
      if (status == ST_UNDER) underflows++;
      if (status == ST_OVER) overflows++;
      if ((hit || needs_read) && status == ST_OK) held_q.push_back(entry_index);
    end
  end

  // Watchdog: ends the run when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      idle_cycles = 0;
    end else if (rst_n) begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results still due",
               idle_cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offers one transaction after a random gap and returns at the edge that takes it.
  // Valid is left high so a back-to-back transaction needs no second assignment.
  task automatic send(action_e act, logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk,
                      logic [BIDX_W-1:0] bidx, logic [STAMP_W-1:0] t);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    device <= dev;
    block_number <= blk;
    buffer_index <= bidx;
    now <= t;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Fields that an operation ignores still carry random values.
  task automatic send_read(logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk,
                           logic [STAMP_W-1:0] t);
    send(ACT_READ, dev, blk, BIDX_W'($urandom), t);
  endtask

  task automatic send_idx(action_e act, logic [BIDX_W-1:0] bidx, logic [STAMP_W-1:0] t);
    send(act, DEV_W'($urandom), $urandom, bidx, t);
  endtask

  // Stops offering until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Usually gives back a held reference, otherwise names any entry.
  function automatic logic [BIDX_W-1:0] pick_held(int pct);
    int                j;
    logic [BIDX_W-1:0] idx;
    if (held_q.size() != 0 && $urandom_range(0, 99) < pct) begin
      j = $urandom_range(0, held_q.size() - 1);
      idx = held_q[j];
      held_q.delete(j);
    end else begin
      idx = BIDX_W'($urandom);
    end
    return idx;
  endfunction

  task automatic release_held();
    logic [BIDX_W-1:0] idx;
    while (held_q.size() != 0) begin
      idx = held_q.pop_front();
      send_idx(ACT_RELEASE, idx, tick);
      tick = tick + 1;
    end
  endtask

  // Fills the whole table with fresh blocks so that further reads are refused,
  // then gives every reference back.
  task automatic fill_table();
    drain();
    release_held();
    repeat (ENTRIES + 4) begin
      send_read(DEV_W'($urandom), $urandom, tick);
      tick = tick + $urandom_range(0, 1);
    end
    drain();
    release_held();
  endtask

  // Drives one entry's count up to saturation and back down past zero, with a read
  // hit on the saturated entry on the way.
  task automatic count_limits();
    logic [DEV_W-1:0]  k_dev;
    logic [BLK_W-1:0]  k_blk;
    logic [BIDX_W-1:0] idx;
    k_dev = DEV_W'($urandom);
    k_blk = $urandom;
    drain();
    send_read(k_dev, k_blk, tick);
    drain();
    idx = last_index;
    repeat (254) send_idx(ACT_PIN, idx, tick);
    send_read(k_dev, k_blk, tick);
    send_idx(ACT_PIN, idx, tick);
    repeat (256) send_idx(ACT_UNPIN, idx, tick);
  endtask

  // One transaction of the ordinary client mix: reads over a small working set of
  // blocks on two devices, releases of held buffers, pins and unpins, and some noise.
  task automatic random_item();
    int                 r;
    logic [STAMP_W-1:0] t;
    logic [BIDX_W-1:0]  idx;
    r = $urandom_range(0, 99);
    tick = tick + $urandom_range(0, 2);
    if (r < 45) begin
      case ($urandom_range(0, 19))
        0:       t = '0;
        1:       t = '1;
        2, 3, 4: t = $urandom;
        default: t = tick;
      endcase
      if ($urandom_range(0, 99) < 85) begin
        send_read(dev_pool[$urandom_range(0, 1)], blk_pool[$urandom_range(0, BLK_POOL - 1)], t);
      end else begin
        send_read(DEV_W'($urandom), $urandom, t);
      end
    end else if (r < 80) begin
      t = ($urandom_range(0, 99) < 3) ? $urandom : tick;
      send_idx(ACT_RELEASE, pick_held(80), t);
    end else if (r < 88) begin
      idx = (held_q.size() != 0) ? held_q[$urandom_range(0, held_q.size() - 1)]
                                 : BIDX_W'($urandom);
      held_q.push_back(idx);
      send_idx(ACT_PIN, idx, tick);
    end else begin
      send_idx(ACT_UNPIN, pick_held(70), tick);
    end
  endtask

  initial begin
    dev_pool[0] = DEV_W'($urandom);
    dev_pool[1] = DEV_W'($urandom);
    foreach (blk_pool[i]) blk_pool[i] = $urandom;
    tick = 200;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. Counts below zero on a fresh table, a pin of an entry that
    // was never tagged, a miss on an all-zero key that no entry holds yet, extreme
    // keys and times, the tie rule, entries excluded for being released after now,
    // a hit on a released entry, and a key that differs only in its device.
    send_idx(ACT_RELEASE, 0, 7);
    send_idx(ACT_UNPIN, 5, 7);
    send_idx(ACT_PIN, 3, 7);
    send_read('0, '0, '0);
    send_read('1, '1, '1);
    send_read('0, '0, 5);
    send_idx(ACT_RELEASE, BIDX_W'(ENTRIES - 1), 100);
    send_idx(ACT_RELEASE, BIDX_W'(ENTRIES - 1), 100);
    send_idx(ACT_RELEASE, 3, 50);
    send_read(8'h5a, 32'h8000_0001, 10);
    send_read(8'ha5, 32'h7fff_fffe, 50);
    send_idx(ACT_UNPIN, BIDX_W'(ENTRIES - 2), 60);
    send_read('0, '0, 100);
    send_idx(ACT_PIN, 7, 110);
    send_idx(ACT_UNPIN, 7, 110);
    send_idx(ACT_RELEASE, 7, 3);
    send_read(8'h5a, 32'h8000_0001, '0);
    send_read(8'h01, '0, '0);
    send(ACT_PIN, '1, '1, '1, '1);

    // First phase: sender idles a quarter of the time, receiver almost half.
    repeat (380) random_item();
    fill_table();

    // Second phase: the idle rates swap. The sender pauses for every result before
    // the count saturation run, and the receiver later holds off for a long stretch
    // while transactions keep coming.
    tx_idle_pct = 45;
    rx_idle_pct <= 26;
    count_limits();
    drain();
    repeat (150) random_item();
    hold_seq <= hold_seq + 1;
    repeat (200) random_item();

    // Last phase: no idling on either side, with one more hold-off.
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    repeat (100) random_item();
    hold_seq <= hold_seq + 1;
    repeat (250) random_item();

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d transactions and %0d checked results: %0d hits, %0d fills,",
             sent, results, hits, fills);
    $display("%0d refused reads, %0d count underflows, %0d count overflows, %0d mismatches",
             refusals, underflows, overflows, errors);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
